### src/lte_pkg.sv
// Shared types, constants and table function for the lidar TTC brake.
package lte_pkg;

    localparam int QUARTER_TURN = 25736;
    localparam int FULL_TURN    = 4 * QUARTER_TURN;
    localparam longint unsigned PIO2_Q30 = 64'd1686629713;
    localparam int FIFO_DEPTH   = 2;
    localparam int NUM_W        = 44;
    localparam int DEN_W        = 17;

    localparam logic OP_SPEED = 1'b0;
    localparam logic OP_BEAM  = 1'b1;

    localparam logic [2:0] REG_TTC   = 3'd0;
    localparam logic [2:0] REG_WIDTH = 3'd1;
    localparam logic [2:0] REG_FRONT = 3'd2;
    localparam logic [2:0] REG_REAR  = 3'd3;
    localparam logic [2:0] REG_AMIN  = 3'd4;
    localparam logic [2:0] REG_AINC  = 3'd5;
    localparam logic [2:0] REG_BEAMS = 3'd6;

    // Taylor series denominators (2n-1)*(2n) for n = 1..12
    localparam longint unsigned Tay_div [12] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };

    typedef struct packed {
        logic signed [15:0] speed;
        logic [11:0]        idx;
        logic [15:0]        range;
        logic               err;
    } t_item;

    typedef struct packed {
        logic [15:0]        brake_thr;
        logic [11:0]        car_width;
        logic [11:0]        front_extent;
        logic [11:0]        rear_extent;
        logic signed [16:0] ang_base;
        logic [9:0]         ang_step;
        logic [12:0]        beam_count;
    } t_cfg;

    typedef enum logic [4:0] {
        ST_IDLE, ST_ANGLE, ST_MOD, ST_QUAD, ST_KGO, ST_KWAIT,
        ST_ROM_A, ST_ROM_B, ST_ROM_C, ST_SGO, ST_SWAIT, ST_EGO, ST_EWAIT,
        ST_RATE, ST_PROD, ST_DONE
    } t_state;

    // Q16 cosine from a Q30 angle, integer Taylor series.
    function automatic logic [16:0] cos_from_x(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          q16;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(term);
        for (int n = 1; n <= 12; n++) begin
            term = ((term * x2) >> 30) / Tay_div[n-1];
            if ((n % 2) == 1) sum = sum - longint'(term);
            else              sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        q16 = (sum + 8192) >>> 14;
        if (q16 > 65536) q16 = 65536;
        return q16[16:0];
    endfunction

endpackage

### src/lte_if.sv
// Beam input and brake result channel interfaces.
interface lte_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [15:0] speed;
    logic [11:0]        beam_index;
    logic [15:0]        beam_range;
    modport source (output valid, opcode, speed, beam_index, beam_range, input ready);
    modport sink   (input valid, opcode, speed, beam_index, beam_range, output ready);
endinterface

interface lte_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] out_index;
    logic        brake;
    logic        index_error;
    modport source (output valid, out_index, brake, index_error, input ready);
    modport sink   (input valid, out_index, brake, index_error, output ready);
endinterface

### src/lidar_ttc_emergency_brake.sv
// Top level of the lidar time-to-collision emergency brake.
// Speed update: accepted without producing a result.
// Beam sample: angle, table lookup, then the one-bit-per-cycle divider run for the side
//   and end outline (a term is skipped when its table entry is zero); the back takes
//   a new beam only after the last result is loaded into its output register.
// Out-of-range beam: no computation, result flagged as an index error. Two-entry queue in front.
// Reset (synchronous, active low): registers to defaults, speed zero, queue empty.
module lidar_ttc_emergency_brake #(
    parameter int MAX_BEAMS        = 4096,
    parameter int TRIG_TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lte_in_if.sink      i_in,
    lte_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lte_pkg::*;

    t_cfg  r_cfg;
    t_item w_fitem, w_qitem;
    logic  w_push, w_pop, w_full, w_empty;
    logic  w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Register file: write on APB access phase, index from paddr[4:2].
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brake_thr    <= 16'd655;
            r_cfg.car_width    <= 12'd300;
            r_cfg.front_extent <= 12'd260;
            r_cfg.rear_extent  <= 12'd70;
            r_cfg.ang_base     <= -17'sd38604;
            r_cfg.ang_step     <= 10'd71;
            r_cfg.beam_count   <= 13'd1081;
        end else if (w_wr) begin
            case (paddr[4:2])
                REG_TTC:   r_cfg.brake_thr    <= pwdata[15:0];
                REG_WIDTH: r_cfg.car_width    <= pwdata[11:0];
                REG_FRONT: r_cfg.front_extent <= pwdata[11:0];
                REG_REAR:  r_cfg.rear_extent  <= pwdata[11:0];
                REG_AMIN:  r_cfg.ang_base     <= $signed(pwdata[16:0]);
                REG_AINC:  r_cfg.ang_step     <= pwdata[9:0];
                REG_BEAMS: r_cfg.beam_count   <= pwdata[12:0];
                default:   r_cfg.beam_count   <= r_cfg.beam_count;
            endcase
        end
    end

    // Read back: the base angle returns sign-extended.
    always_comb begin
        case (paddr[4:2])
            REG_TTC:   prdata = {16'b0, r_cfg.brake_thr};
            REG_WIDTH: prdata = {20'b0, r_cfg.car_width};
            REG_FRONT: prdata = {20'b0, r_cfg.front_extent};
            REG_REAR:  prdata = {20'b0, r_cfg.rear_extent};
            REG_AMIN:  prdata = 32'(r_cfg.ang_base);
            REG_AINC:  prdata = {22'b0, r_cfg.ang_step};
            REG_BEAMS: prdata = {19'b0, r_cfg.beam_count};
            default:   prdata = '0;
        endcase
    end

    // Front: classify and stamp each beam with the current speed.
    lte_front #(.MAX_BEAMS(MAX_BEAMS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_beam_count (r_cfg.beam_count),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_item       (w_fitem)
    );

    // Queue decouples input acceptance from the long back-end computation.
    lte_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .i_pop   (w_pop),
        .o_item  (w_qitem),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Back: one beam at a time, result held in an output register.
    lte_back #(.DEPTH(TRIG_TABLE_DEPTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (w_empty),
        .i_item  (w_qitem),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );
endmodule

### src/lte_rom.sv
// Quarter-wave cosine table, registered read.
module lte_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic [$clog2(DEPTH+1)-1:0] i_addr,
    output logic [16:0]                o_data
);
    import lte_pkg::*;

    logic [16:0] w_tab [DEPTH+1];
    logic [16:0] r_data;

    for (genvar g = 0; g <= DEPTH; g++) begin : g_ent
        localparam longint unsigned X_G = (longint'(g) * PIO2_Q30) / DEPTH;
        assign w_tab[g] = cos_from_x(X_G);
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_tab[i_addr];
    end

    assign o_data = r_data;
endmodule

### src/lte_div.sv
// Restoring divider, one quotient bit per cycle.
module lte_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [lte_pkg::NUM_W-1:0] i_num,
    input  logic [lte_pkg::DEN_W-1:0] i_den,
    output logic                     o_done,
    output logic [lte_pkg::NUM_W-1:0] o_quo
);
    import lte_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy, r_done;
    logic [DEN_W:0]   w_trial;

    assign w_trial = {r_rem, r_quo[NUM_W-1]};

    always_comb begin
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = DEN_W'(w_trial - {1'b0, r_den});
            n_quo = {r_quo[NUM_W-2:0], 1'b1};
        end else begin
            n_rem = w_trial[DEN_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

### src/lte_fifo.sv
// Short queue of classified beam items between front and back.
module lte_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lte_pkg::t_item  i_item,
    input  logic            i_pop,
    output lte_pkg::t_item  o_item,
    output logic            o_full,
    output logic            o_empty
);
    import lte_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    t_item               r_mem [FIFO_DEPTH];
    logic [PW-1:0]       r_wp, r_rp;
    logic [$clog2(FIFO_DEPTH+1)-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    assign o_item  = r_mem[r_rp];
    assign o_full  = (r_cnt == ($bits(r_cnt))'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
endmodule

### src/lte_front.sv
// Front end: accept items, track speed, flag bad indexes, queue beams.
module lte_front #(
    parameter int MAX_BEAMS = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lte_in_if.sink         i_in,
    input  logic [12:0]    i_beam_count,
    input  logic           i_full,
    output logic           o_push,
    output lte_pkg::t_item o_item
);
    import lte_pkg::*;

    localparam logic [16:0] MAXB = 17'(MAX_BEAMS);

    logic signed [15:0] r_speed;
    logic               w_acc;

    assign i_in.ready = !i_full;
    assign w_acc      = i_in.valid && !i_full;
    assign o_push     = w_acc && (i_in.opcode == OP_BEAM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
        end else if (w_acc && i_in.opcode == OP_SPEED) begin
            r_speed <= i_in.speed;
        end
    end

    // each beam carries the speed in force when it arrived
    always_comb begin
        o_item.speed = r_speed;
        o_item.idx   = i_in.beam_index;
        o_item.range = i_in.beam_range;
        o_item.err   = ({1'b0, i_in.beam_index} >= i_beam_count) ||
                       ({5'b0, i_in.beam_index} >= MAXB);
    end
endmodule

### src/lte_back.sv
// Back end: angle, table lookup, outline division and brake decision.
module lte_back #(
    parameter int DEPTH = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lte_pkg::t_cfg  i_cfg,
    input  logic           i_empty,
    input  lte_pkg::t_item i_item,
    output logic           o_pop,
    lte_out_if.source      o_out
);
    import lte_pkg::*;

    localparam int RW = $clog2(DEPTH + 1);
    localparam logic [22:0] FULL23 = 23'(FULL_TURN);
    localparam logic [RW-1:0] DEPTH_R = RW'(DEPTH);
    // ceil(2^32 * DEPTH / QUARTER_TURN): table index by reciprocal multiply
    localparam logic [31:0] KMUL = 32'(((longint'(DEPTH) << 32)
                                       + longint'(QUARTER_TURN) - 1)
                                       / longint'(QUARTER_TURN));

    t_state r_st, n_st;
    t_item  r_item;
    logic [22:0]        r_a;
    logic [2:0]         r_step;
    logic [1:0]         r_quad;
    logic [14:0]        r_r;
    logic [46:0]        r_kp;
    logic [RW-1:0]      r_k;
    logic [16:0]        r_ck, r_cmag, r_smag;
    logic [NUM_W-1:0]   r_outline;
    logic               r_side_ok;
    logic signed [33:0] r_rate;
    logic               r_pos;
    logic [46:0]        r_prod;
    logic signed [45:0] r_diff;

    logic               r_ovalid, r_obrake, r_oerr;
    logic [11:0]        r_oidx;

    logic               w_free, w_load, w_start;
    logic [NUM_W-1:0]   w_num;
    logic [DEN_W-1:0]   w_den;
    logic [RW-1:0]      w_addr;
    logic [16:0]        w_rom;
    logic               w_ddone;
    logic [NUM_W-1:0]   w_quo;
    logic [22:0]        w_sub;
    logic signed [17:0] w_cosv;
    logic [11:0]        w_ext;
    logic               w_lt;

    assign w_free = !r_ovalid || o_out.ready;
    assign w_sub  = FULL23 << r_step;
    assign w_ext  = (r_quad[1] == 1'b0) ? i_cfg.front_extent : i_cfg.rear_extent;
    assign w_cosv = (r_quad == 2'd0 || r_quad == 2'd3) ? $signed({1'b0, r_cmag})
                                                       : -$signed({1'b0, r_cmag});
    assign w_lt   = $signed({r_diff, 16'b0}) < $signed({15'b0, r_prod});

    lte_rom #(.DEPTH(DEPTH)) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_addr),
        .o_data (w_rom)
    );

    lte_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:  if (!i_empty) n_st = i_item.err ? ST_DONE : ST_ANGLE;
            ST_ANGLE: n_st = ST_MOD;
            ST_MOD:   if (r_step == 3'd0) n_st = ST_QUAD;
            ST_QUAD:  n_st = ST_KGO;
            ST_KGO:   n_st = ST_KWAIT;
            ST_KWAIT: n_st = ST_ROM_A;
            ST_ROM_A: n_st = ST_ROM_B;
            ST_ROM_B: n_st = ST_ROM_C;
            ST_ROM_C: n_st = ST_SGO;
            ST_SGO:   n_st = (r_cmag != '0) ? ST_SWAIT : ST_EGO;
            ST_SWAIT: if (w_ddone) n_st = ST_EGO;
            ST_EGO:   n_st = (r_smag != '0) ? ST_EWAIT : ST_RATE;
            ST_EWAIT: if (w_ddone) n_st = ST_RATE;
            ST_RATE:  n_st = ST_PROD;
            ST_PROD:  n_st = ST_DONE;
            ST_DONE:  if (w_free) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop   = 1'b0;
        w_start = 1'b0;
        w_load  = 1'b0;
        w_num   = '0;
        w_den   = '0;
        w_addr  = r_k;
        case (r_st)
            ST_IDLE:  o_pop = !i_empty;
            ST_ROM_B: w_addr = DEPTH_R - r_k;
            ST_SGO: begin
                w_start = (r_cmag != '0);
                w_num   = NUM_W'({i_cfg.car_width, 31'b0});
                w_den   = r_cmag;
            end
            ST_EGO: begin
                w_start = (r_smag != '0);
                w_num   = {w_ext, 32'b0};
                w_den   = r_smag;
            end
            ST_DONE:  w_load = w_free;
            default:  w_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (w_load)            r_ovalid <= 1'b1;
            else if (o_out.ready)  r_ovalid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                r_item    <= i_item;
                r_step    <= 3'd5;
                r_side_ok <= 1'b0;
                r_pos     <= 1'b0;
            end
            ST_ANGLE: begin
                r_a <= 23'($signed({{8{i_cfg.ang_base[16]}}, i_cfg.ang_base})
                     + $signed({3'b0, 22'(r_item.idx) * 22'(i_cfg.ang_step)})
                     + $signed(25'(FULL_TURN)));
            end
            ST_MOD: begin
                if (r_a >= w_sub) r_a <= r_a - w_sub;
                r_step <= r_step - 1'b1;
            end
            ST_QUAD: begin
                if (r_a >= 23'(3 * QUARTER_TURN)) begin
                    r_quad <= 2'd3;
                    r_r    <= 15'(r_a - 23'(3 * QUARTER_TURN));
                end else if (r_a >= 23'(2 * QUARTER_TURN)) begin
                    r_quad <= 2'd2;
                    r_r    <= 15'(r_a - 23'(2 * QUARTER_TURN));
                end else if (r_a >= 23'(QUARTER_TURN)) begin
                    r_quad <= 2'd1;
                    r_r    <= 15'(r_a - 23'(QUARTER_TURN));
                end else begin
                    r_quad <= 2'd0;
                    r_r    <= r_a[14:0];
                end
            end
            ST_KGO:   r_kp <= 47'(r_r) * 47'(KMUL);
            ST_KWAIT: r_k  <= r_kp[32 +: RW];
            ST_ROM_B: r_ck <= w_rom;
            ST_ROM_C: begin
                r_cmag <= r_quad[0] ? w_rom : r_ck;
                r_smag <= r_quad[0] ? r_ck  : w_rom;
            end
            ST_SWAIT: if (w_ddone) begin
                r_outline <= w_quo;
                r_side_ok <= 1'b1;
            end
            ST_EWAIT: if (w_ddone && (!r_side_ok || w_quo < r_outline)) begin
                r_outline <= w_quo;
            end
            ST_RATE: begin
                r_rate <= 34'(r_item.speed * w_cosv);
                if (!r_side_ok && r_smag == '0) r_outline <= '0;
            end
            ST_PROD: begin
                r_pos  <= r_rate > 0;
                r_prod <= r_item.err ? '0 : i_cfg.brake_thr * r_rate[31:0];
                r_diff <= $signed({14'b0, r_item.range, 16'b0})
                        - $signed({2'b0, r_outline});
            end
            ST_DONE: if (w_load) begin
                r_oidx   <= r_item.idx;
                r_oerr   <= r_item.err;
                r_obrake <= !r_item.err && r_pos && w_lt;
            end
            default: r_a <= r_a;
        endcase
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.out_index   = r_oidx;
    assign o_out.brake       = r_obrake;
    assign o_out.index_error = r_oerr;
endmodule

### src/lte_chk.sv
// Port-level checker for the lidar TTC brake, bound to the top level.
module lte_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] out_index,
    input logic        out_brake,
    input logic        out_err,
    input logic        pready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_brake))
        else $error("result dropped while stalled");

    a_err_no_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !(out_err && out_brake))
        else $error("brake on out-of-range beam");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");
endmodule

bind lidar_ttc_emergency_brake lte_chk u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_index (o_out.out_index),
    .out_brake (o_out.brake),
    .out_err   (o_out.index_error),
    .pready    (pready)
);

### tb/tb_lidar_ttc_emergency_brake.sv
// Self-checking testbench for the lidar time-to-collision emergency brake.
`timescale 1ns / 1ps

module tb_lidar_ttc_emergency_brake;

    import lte_pkg::*;

    localparam int COS_DEPTH  = 1024;
    localparam int BEAM_LIMIT = 4096;
    // Leave margin after the worst beam latency before idle writes.
    localparam int SETTLE_CYCLES = 250;
    localparam int LONG_HOLD     = 400;

    // Mirror of the brake datapath: config, current speed, cosine table and
    // the queue of brake decisions still owed by the block.
    class brake_scoreboard;
        typedef struct {
            logic [11:0] idx;
            logic        brake;
            logic        err;
        } brake_exp_t;

        brake_exp_t  owed_q[$];
        int          errors;
        longint      cos_q16 [0:COS_DEPTH];
        int unsigned ttc_thr, width_mm, front_mm, rear_mm, step, beams;
        int          amin;
        longint      speed_now;

        function new();
            longint unsigned x, x2, term;
            longint          acc, q16;
            for (int k = 0; k <= COS_DEPTH; k++) begin
                x    = longint'(k) * PIO2_Q30 / COS_DEPTH;
                x2   = (x * x) >> 30;
                term = 64'd1 << 30;
                acc  = longint'(term);
                for (int n = 1; n <= 12; n++) begin
                    term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
                    if (n % 2 == 1) acc = acc - longint'(term);
                    else            acc = acc + longint'(term);
                end
                if (acc < 0) acc = 0;
                q16 = (acc + 8192) >>> 14;
                if (q16 > 65536) q16 = 65536;
                cos_q16[k] = q16;
            end
            errors = 0;
            load_defaults();
        endfunction

        function void load_defaults();
            ttc_thr  = 655;
            width_mm = 300;
            front_mm = 260;
            rear_mm  = 70;
            amin     = -38604;
            step     = 71;
            beams    = 1081;
            speed_now = 0;
        endfunction

        function void set_reg(logic [2:0] regi, int value);
            case (regi)
                REG_TTC:   ttc_thr  = value & 16'hFFFF;
                REG_WIDTH: width_mm = value & 12'hFFF;
                REG_FRONT: front_mm = value & 12'hFFF;
                REG_REAR:  rear_mm  = value & 12'hFFF;
                REG_AMIN:  amin     = int'($signed(value[16:0]));
                REG_AINC:  step     = value & 10'h3FF;
                REG_BEAMS: beams    = value & 13'h1FFF;
                default: ;
            endcase
        endfunction

        // Record one accepted transaction: a speed update, or the brake decision for a beam.
        function void note_input(logic op, logic signed [15:0] spd,
                                 logic [11:0] idx, logic [15:0] rng);
            brake_exp_t      e;
            longint          a, r, k, cosv, rate, diff;
            longint unsigned cmag, smag, ext, outline, end_term;
            int              quad, lim;
            if (op == OP_SPEED) begin
                speed_now = spd;
                return;
            end
            e.idx   = idx;
            e.brake = 1'b0;
            e.err   = 1'b0;
            lim = (beams < BEAM_LIMIT) ? beams : BEAM_LIMIT;
            if (int'(idx) >= lim) begin
                e.err = 1'b1;
                owed_q = {owed_q, e};
                return;
            end
            a    = longint'(amin) + longint'(idx) * longint'(step);
            a    = ((a % FULL_TURN) + FULL_TURN) % FULL_TURN;
            quad = int'(a / QUARTER_TURN);
            r    = a % QUARTER_TURN;
            k    = r * COS_DEPTH / QUARTER_TURN;
            if (quad == 0 || quad == 2) begin
                cmag = cos_q16[k];
                smag = cos_q16[COS_DEPTH - k];
            end else begin
                cmag = cos_q16[COS_DEPTH - k];
                smag = cos_q16[k];
            end
            cosv = (quad == 0 || quad == 3) ? longint'(cmag) : -longint'(cmag);
            ext  = (quad <= 1) ? front_mm : rear_mm;
            // Zero table entry: that outline term is unbounded, use the other.
            outline = 0;
            if (cmag != 0) outline = (longint'(width_mm) << 31) / cmag;
            if (smag != 0) begin
                end_term = (ext << 32) / smag;
                if (cmag == 0 || end_term < outline) outline = end_term;
            end
            rate = speed_now * cosv;
            if (rate > 0) begin
                diff = (longint'(rng) << 16) - longint'(outline);
                if (diff * 65536 < longint'(ttc_thr) * rate) e.brake = 1'b1;
            end
            owed_q = {owed_q, e};
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task check(logic [11:0] idx, logic brake, logic err);
            brake_exp_t e;
            if (owed_q.size() == 0) begin
                report($sformatf("unexpected result idx=%0d", idx));
                return;
            end
            e = owed_q.pop_front();
            if (idx !== e.idx)
                report($sformatf("out_index %0d, want %0d", idx, e.idx));
            if (brake !== e.brake)
                report($sformatf("brake %b, want %b (idx %0d)", brake, e.brake, e.idx));
            if (err !== e.err)
                report($sformatf("index_error %b, want %b (idx %0d)", err, e.err, e.idx));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;

    lte_in_if  in_ch ();
    lte_out_if out_ch ();

    brake_scoreboard sb = new();

    bit fast_mode;   // sender and receiver skip idling while set
    bit hold_req;    // receiver holds off for a long stretch when set

    always #6 i_clk = ~i_clk;

    lidar_ttc_emergency_brake dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Monitors: sample handshakes at the edge, before the edge's updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            sb.note_input(in_ch.opcode, in_ch.speed, in_ch.beam_index, in_ch.beam_range);
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check(out_ch.out_index, out_ch.brake, out_ch.index_error);
    end

    function automatic int draw_gap();
        return fast_mode ? 0 : $urandom_range(0, 15);
    endfunction

    // Receiver: stall a random number of cycles, then take one transaction.
    initial begin
        int n;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end
            n = draw_gap();
            if (n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Offer one transaction after a random gap; return once it is accepted.
    task send(logic op, logic [15:0] spd, logic [11:0] idx, logic [15:0] rng);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= op;
        in_ch.speed      <= spd;
        in_ch.beam_index <= idx;
        in_ch.beam_range <= rng;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task speed_upd(logic [15:0] spd);
        send(OP_SPEED, spd, 12'($urandom), 16'($urandom));
    endtask

    task beam(logic [11:0] idx, logic [15:0] rng);
        send(OP_BEAM, 16'($urandom), idx, rng);
    endtask

    // Drop valid and wait until every owed result has come back.
    task drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed_q.size() != 0) @(posedge i_clk);
    endtask

    task reg_write(logic [2:0] regi, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {regi, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(regi, value);
    endtask

    // Reprogram every register with the block idle.
    task set_config(int thr, int wid, int fr, int rr, int am, int inc, int bc);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        reg_write(REG_TTC, thr);
        reg_write(REG_WIDTH, wid);
        reg_write(REG_FRONT, fr);
        reg_write(REG_REAR, rr);
        reg_write(REG_AMIN, am);
        reg_write(REG_AINC, inc);
        reg_write(REG_BEAMS, bc);
    endtask

    // Random traffic: mostly beams inside the scan with short ranges so brake
    // decisions go both ways; some speed updates and out-of-scan indexes.
    task random_traffic(int n);
        int lim, sel;
        logic [11:0] idx;
        logic [15:0] rng;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) fast_mode = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 99);
            lim = (sb.beams < BEAM_LIMIT) ? sb.beams : BEAM_LIMIT;
            if (sel < 15) begin
                if ($urandom_range(0, 2) != 0) speed_upd(16'($urandom_range(0, 32767)));
                else                           speed_upd(16'($urandom));
            end else begin
                if (sel < 88 && lim > 0) idx = 12'($urandom_range(0, lim - 1));
                else                     idx = 12'($urandom);
                case ($urandom_range(0, 2))
                    0:       rng = 16'($urandom_range(0, 600));
                    1:       rng = 16'($urandom_range(0, 4000));
                    default: rng = 16'($urandom);
                endcase
                beam(idx, rng);
            end
        end
        fast_mode = 1'b0;
    endtask

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.opcode     = OP_SPEED;
        in_ch.speed      = '0;
        in_ch.beam_index = '0;
        in_ch.beam_range = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        fast_mode = 1'b0;
        hold_req  = 1'b0;
        i_rst_n   = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset config, zero speed, then extremes of speed and range.
        beam(12'd544, 16'd0);            // zero speed: no brake
        speed_upd(16'sd32767);
        beam(12'd544, 16'd0);            // range inside outline
        beam(12'd544, 16'd65535);
        beam(12'd0, 16'd100);
        beam(12'd1080, 16'd200);
        beam(12'd1081, 16'd10);          // first index past the scan
        beam(12'd4095, 16'd10);
        speed_upd(16'h8000);             // most negative speed
        beam(12'd544, 16'd0);
        speed_upd(16'hFFFF);
        beam(12'd0, 16'd0);
        speed_upd(16'sd1);
        beam(12'd544, 16'd0);

        // Zero cosine at a quarter turn, zero sine at angle zero.
        set_config(65535, 4095, 4095, 4095, QUARTER_TURN, 0, 4096);
        speed_upd(16'sd20000);
        beam(12'd5, 16'd3000);
        set_config(65535, 4095, 4095, 4095, 0, 0, 8191);
        beam(12'd4095, 16'd3000);
        beam(12'd0, 16'd65535);
        // Empty scan: every beam flags.
        set_config(0, 0, 0, 0, 0, 0, 0);
        beam(12'd0, 16'd0);
        beam(12'd4095, 16'd65535);

        // Random phases over several settings, extremes among them.
        set_config(65535, 4095, 4095, 4095, 51472, 1023, 4096);
        random_traffic(180);
        set_config(655, 300, 260, 70, -51472, 1023, 4096);
        hold_req = 1'b1;                 // block fills and stalls its input
        random_traffic(180);
        set_config(0, 0, 0, 0, 0, 25, 1000);
        random_traffic(150);
        set_config(655, 300, 260, 70, -38604, 71, 1081);
        random_traffic(100);
        drain();                         // sender pauses until all results are in
        random_traffic(100);
        for (int p = 0; p < 6; p++) begin
            set_config($urandom_range(0, 65535), $urandom_range(0, 4095),
                       $urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 102944) - 51472, $urandom_range(0, 1023),
                       $urandom_range(0, 4096));
            if (p == 3) hold_req = 1'b1;
            random_traffic(200);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
src/lte_pkg.sv
src/lte_if.sv
src/lte_rom.sv
src/lte_div.sv
src/lte_fifo.sv
src/lte_front.sv
src/lte_back.sv
src/lidar_ttc_emergency_brake.sv
src/lte_chk.sv
tb/tb_lidar_ttc_emergency_brake.sv
